>>> hw/rtl/pfx_eval_pkg.sv
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Types, codes and helpers shared by the postfix evaluator files.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ValW    = 32;

  typedef enum logic [OpW-1:0] {
    OP_NUM = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_DIVZERO = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_BADEND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_ITER = 3'd2,
    S_FIN  = 3'd3,
    S_OUT  = 3'd4
  } state_e;

  // saturate a sign and magnitude pair to signed 32 bits
  function automatic logic [ValW-1:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [ValW-1:0] res;
    if (neg) begin
      if (mag >= 64'h0000_0000_8000_0000) res = 32'h8000_0000;
      else res = (~mag[ValW-1:0]) + 32'd1;
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[ValW-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/postfix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix evaluator on an operand stack, signed fixed point arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one token per transaction: tuser is the token kind,
//   tdata the Q16.16 operand for a number, tlast marks the final token.
//   Master stream returns one result per token: tuser is the status, tdata
//   the top of stack, tlast the final verdict of the expression.
// Sequencing:
//   Number, add, subtract and any token after an error: execute, then output.
//   Multiply: execute, the 32 steps of the shift-add loop, finish, then output.
//   Divide: execute, the restoring divide loop, finish, then output.
//   Both loops share one 33-bit add/subtract unit.
//   s_axis_tready_o is high only while no token is in work.
// Reset:
//   Depth, sticky error and operator flag clear; stack memory is not cleared.
//   No transaction is pending on the master side after reset.
// Stall:
//   A result waits in the output register until taken; the next token is
//   still accepted, its result waits until the register is free.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core import pfx_eval_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // number
  input  logic [2:0]  s_axis_tuser_i,   // operation
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // top_value
  output logic [2:0]  m_axis_tuser_o,   // status
  output logic        m_axis_tlast_o    // done_res
);

  localparam int unsigned DW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned QW    = 32 + FRAC_BITS;
  localparam int unsigned ACC_W = QW + 33;
  localparam int unsigned CW    = $clog2(QW);

  state_e             state_q, state_d;
  logic [DW-1:0]      depth_q, depth_d;
  status_e            err_q, err_d;
  logic               prev_q, prev_d;
  logic [31:0]        top_q, top_d;
  logic [2:0]         op_q;
  logic [31:0]        num_q;
  logic               last_q;
  logic               div_q, div_d;
  logic               neg_q, neg_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [31:0]        opnd_q, opnd_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               m_valid_q, m_valid_d;
  logic [31:0]        m_data_q;
  logic [2:0]         m_user_q;
  logic               m_last_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;

  logic               in_fire;
  logic               out_load;
  logic [2:0]         out_status;
  logic [DW-1:0]      depth_m2;
  logic [31:0]        mag_a, mag_b;
  logic [32:0]        sum_ab, dif_ab;
  logic [32:0]        add_x;
  logic [33:0]        add_res;
  logic [32:0]        hi_new;
  logic [64:0]        mul_t;
  logic               qbit;
  logic [31:0]        new_rem;
  logic [ACC_W-1:0]   step_next;
  logic [63:0]        fin_mag;
  logic [31:0]        fin_res;

  pfx_eval_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign depth_m2  = depth_q - DW'(2);
  assign ram_raddr = depth_m2[AW-1:0];
  assign in_fire   = s_axis_tvalid_i & s_axis_tready_o;

  // operands: a from memory, b is the cached top
  assign mag_a  = ram_rdata[31] ? (~ram_rdata + 32'd1) : ram_rdata;
  assign mag_b  = top_q[31] ? (~top_q + 32'd1) : top_q;
  assign sum_ab = {ram_rdata[31], ram_rdata} + {top_q[31], top_q};
  assign dif_ab = {ram_rdata[31], ram_rdata} - {top_q[31], top_q};

  // shared add/subtract unit for the multiply and divide loops
  assign add_x   = div_q ? acc_q[QW+31:QW-1] : {1'b0, acc_q[63:32]};
  assign add_res = div_q ? ({1'b0, add_x} - {2'b00, opnd_q})
                         : ({1'b0, add_x} + {2'b00, opnd_q});
  assign hi_new  = acc_q[0] ? add_res[32:0] : add_x;
  assign mul_t   = {hi_new, acc_q[31:0]};
  assign qbit    = ~add_res[33];
  assign new_rem = qbit ? add_res[31:0] : add_x[31:0];
  assign step_next = div_q ? {1'b0, new_rem, acc_q[QW-2:0], qbit}
                           : ACC_W'(mul_t[64:1]);

  assign fin_mag = div_q ? 64'(acc_q[QW-1:0]) : (acc_q[63:0] >> FRAC_BITS);
  assign fin_res = sat_mag(neg_q, fin_mag);

  always_comb begin
    out_status = err_q;
    if (last_q && (err_q == ST_OK) && ((depth_q != DW'(1)) || !prev_q)) begin
      out_status = ST_BADEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      depth_q   <= '0;
      err_q     <= ST_OK;
      prev_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      depth_q   <= depth_d;
      err_q     <= err_d;
      prev_q    <= prev_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    cnt_q  <= cnt_d;
    if (in_fire) begin
      op_q   <= s_axis_tuser_i;
      num_q  <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (out_load) begin
      m_data_q <= (depth_q != '0) ? top_q : 32'd0;
      m_user_q <= out_status;
      m_last_q <= last_q;
    end
  end

  always_comb begin
    state_d         = state_q;
    depth_d         = depth_q;
    err_d           = err_q;
    prev_d          = prev_q;
    top_d           = top_q;
    div_d           = div_q;
    neg_d           = neg_q;
    acc_d           = acc_q;
    opnd_d          = opnd_q;
    cnt_d           = cnt_q;
    ram_we          = 1'b0;
    ram_waddr       = depth_m2[AW-1:0];
    ram_wdata       = fin_res;
    out_load        = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        prev_d  = (op_q >= 3'(OP_ADD)) && (op_q <= 3'(OP_DIV));
        neg_d   = ram_rdata[31] ^ top_q[31];
        if (err_q == ST_OK) begin
          unique case (op_q) inside
            OP_NUM: begin
              if (depth_q >= DW'(STACK_DEPTH)) begin
                err_d = ST_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = depth_q[AW-1:0];
                ram_wdata = num_q;
                top_d     = num_q;
                depth_d   = depth_q + DW'(1);
              end
            end
            OP_ADD, OP_SUB: begin
              if (depth_q < DW'(2)) begin
                err_d = ST_UNDER;
              end else begin
                if (op_q == OP_ADD) begin
                  ram_wdata = (sum_ab[32] != sum_ab[31])
                              ? (sum_ab[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                              : sum_ab[31:0];
                end else begin
                  ram_wdata = (dif_ab[32] != dif_ab[31])
                              ? (dif_ab[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                              : dif_ab[31:0];
                end
                ram_we  = 1'b1;
                top_d   = ram_wdata;
                depth_d = depth_q - DW'(1);
              end
            end
            OP_MUL: begin
              if (depth_q < DW'(2)) begin
                err_d = ST_UNDER;
              end else begin
                acc_d   = ACC_W'(mag_b);
                opnd_d  = mag_a;
                div_d   = 1'b0;
                cnt_d   = CW'(31);
                state_d = S_ITER;
              end
            end
            OP_DIV: begin
              if (depth_q < DW'(2)) begin
                err_d = ST_UNDER;
              end else if (top_q == 32'd0) begin
                err_d = ST_DIVZERO;
              end else begin
                acc_d   = ACC_W'(mag_a) << FRAC_BITS;
                opnd_d  = mag_b;
                div_d   = 1'b1;
                cnt_d   = CW'(QW - 1);
                state_d = S_ITER;
              end
            end
            default: begin
              err_d = ST_BADEND;
            end
          endcase
        end
      end
      S_ITER: begin
        acc_d = step_next;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_FIN: begin
        ram_we  = 1'b1;
        top_d   = fin_res;
        depth_d = depth_q - DW'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (last_q) begin
            depth_d = '0;
            err_d   = ST_OK;
            prev_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

>>> hw/rtl/pfx_eval_ram.sv
// ----------------------------------------------------------------------------
// pfx_eval_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfx_eval_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/pfx_eval_checker.sv
// ----------------------------------------------------------------------------
// pfx_eval_checker
// Port-level checks for the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfx_eval_checker import pfx_eval_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,   // top_value
  input logic [2:0]  m_axis_tuser_o,   // status
  input logic        m_axis_tlast_o    // done_res
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // busy right after a token is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("token accepted while busy");

  // a new result appears only out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without work");

  // status code stays within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_DIVZERO)
      || (m_axis_tuser_o == ST_UNDER) || (m_axis_tuser_o == ST_OVER)
      || (m_axis_tuser_o == ST_BADEND))
    else $error("status out of range");

endmodule

bind postfix_expression_evaluator_core pfx_eval_checker u_pfx_eval_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the postfix evaluator core. Token streams of whole
// expressions (well formed, truncated, overflowing, underflowing, noise) are
// fed through the slave port while an in-bench Q16.16 stack calculator
// predicts every result, which is compared on the master port. Both ports
// idle at random, and the receiver holds off once long enough to back up
// the input.
// ----------------------------------------------------------------------------
module tb_top;
  import pfx_eval_pkg::*;

  localparam int unsigned STACK_N      = 16;
  localparam int unsigned FRAC_N       = 16;
  localparam int unsigned RANDOM_TOKENS = 750;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned OP_CODE_MAX  = (1 << OpW) - 1;

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_LSB  = 32'h0000_0001;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [ValW-1:0] num;
    logic            last;
  } token_t;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] top;
    logic            done;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic            tok_valid = 1'b0;
  logic            tok_ready;
  logic [31:0]     tok_num = '0;
  logic [OpW-1:0]  tok_op = '0;
  logic            tok_last = 1'b0;
  logic            res_valid;
  logic            res_ready = 1'b0;
  logic [31:0]     res_top;
  logic [2:0]      res_status;
  logic            res_done;

  token_t   token_stream[$];
  outcome_t rpn_outcomes[$];

  logic signed [ValW-1:0] calc_stack[STACK_N];
  int unsigned            calc_depth = 0;
  status_e                calc_err = ST_OK;

  int unsigned cyc = 0;
  int unsigned tokens_planned = 0;
  int unsigned tokens_in = 0;
  int unsigned results_seen = 0;
  int unsigned verdicts = 0;
  int unsigned errors = 0;
  int unsigned verdict_hits[5] = '{default: 0};
  logic        tok_acc = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  postfix_expression_evaluator_core #(
    .STACK_DEPTH(STACK_N),
    .FRAC_BITS  (FRAC_N)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(tok_valid),
    .s_axis_tready_o(tok_ready),
    .s_axis_tdata_i (tok_num),     // number
    .s_axis_tuser_i (tok_op),      // operation
    .s_axis_tlast_i (tok_last),    // last
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_top),     // top_value
    .m_axis_tuser_o (res_status),  // status
    .m_axis_tlast_o (res_done)     // done_res
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned abs_q(input logic signed [ValW-1:0] v);
    return (v < 0) ? longint'(-longint'(v)) : longint'(v);
  endfunction

  function automatic logic [ValW-1:0] clamp_q(input longint signed v);
    if (v > longint'(32'sh7FFF_FFFF)) return Q_MAX;
    if (v < -longint'(64'sd2147483648)) return Q_MIN;
    return v[ValW-1:0];
  endfunction

  task automatic rpn_evaluate_token(input token_t t);
    outcome_t               o;
    logic signed [ValW-1:0] a;
    logic signed [ValW-1:0] b;
    longint signed          wide;
    longint unsigned        mag;
    logic                   neg;
    logic                   is_opr;
    is_opr = (t.op >= OP_ADD) && (t.op <= OP_DIV);
    wide = 0;
    if (calc_err == ST_OK) begin
      if (t.op == OP_NUM) begin
        if (calc_depth >= STACK_N) begin
          calc_err = ST_OVER;
        end else begin
          calc_stack[calc_depth] = t.num;
          calc_depth++;
        end
      end else if (!is_opr) begin
        calc_err = ST_BADEND;
      end else if (calc_depth < 2) begin
        calc_err = ST_UNDER;
      end else begin
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        neg = (a < 0) != (b < 0);
        case (t.op)
          OP_ADD: wide = longint'(a) + longint'(b);
          OP_SUB: wide = longint'(a) - longint'(b);
          OP_MUL: begin
            mag = (abs_q(a) * abs_q(b)) >> FRAC_N;
            wide = neg ? -longint'(mag) : longint'(mag);
          end
          default: begin
            if (b == 0) begin
              calc_err = ST_DIVZERO;
            end else begin
              mag = (abs_q(a) << FRAC_N) / abs_q(b);
              wide = neg ? -longint'(mag) : longint'(mag);
            end
          end
        endcase
        if (calc_err == ST_OK) begin
          calc_depth--;
          calc_stack[calc_depth-1] = clamp_q(wide);
        end
      end
    end
    o.status = calc_err;
    if (t.last && calc_err == ST_OK && (calc_depth != 1 || !is_opr)) o.status = ST_BADEND;
    o.top  = (calc_depth > 0) ? calc_stack[calc_depth-1] : Q_ZERO;
    o.done = t.last;
    rpn_outcomes.push_back(o);
    if (t.last) begin
      calc_depth = 0;
      calc_err   = ST_OK;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned idle_len();
    int unsigned r;
    if (cyc[10:9] == 2'b11) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ZERO;
      3: return (ValW)'($urandom_range(0, 20) - 10) << FRAC_N;
      4, 5: return $urandom_range(0, 1) ? (ValW)'($urandom_range(0, 32'h3FFFF))
                                        : -(ValW)'($urandom_range(0, 32'h3FFFF));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_token(input int unsigned op, input logic [ValW-1:0] num,
                           input logic last);
    token_t t;
    t.op   = op[OpW-1:0];
    t.num  = num;
    t.last = last;
    token_stream.push_back(t);
    tokens_planned++;
  endtask

  task automatic add_push(input logic last);
    add_token(OP_NUM, pick_value(), last);
  endtask

  task automatic add_operator(input logic last);
    add_token($urandom_range(OP_ADD, OP_DIV), $urandom, last);
  endtask

  task automatic add_well_formed();
    int unsigned pushes;
    int unsigned depth;
    logic        deep;
    pushes = ($urandom_range(0, 9) == 0) ? STACK_N : $urandom_range(2, 8);
    deep = ($urandom_range(0, 3) == 0);
    depth = 0;
    while (pushes > 0 || depth > 1) begin
      if (depth >= 2 && (pushes == 0 || (!deep && $urandom_range(0, 1)))) begin
        depth--;
        add_operator(pushes == 0 && depth == 1);
      end else begin
        pushes--;
        depth++;
        add_push(1'b0);
      end
    end
  endtask

  task automatic add_broken();
    int unsigned n;
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 12);
        for (int unsigned i = 1; i <= n; i++)
          add_token($urandom_range(OP_NUM, OP_CODE_MAX), $urandom, i == n);
      end
      1: begin
        n = STACK_N + 1 + $urandom_range(0, 2);
        for (int unsigned i = 1; i <= n; i++) add_push(1'b0);
        if ($urandom_range(0, 1)) add_operator(1'b1);
        else add_push(1'b1);
      end
      2: begin
        n = $urandom_range(0, 1);
        for (int unsigned i = 0; i < n; i++) add_push(1'b0);
        add_operator(1'b0);
        n = $urandom_range(0, 3);
        for (int unsigned i = 0; i < n; i++) add_push(1'b0);
        add_operator(1'b1);
      end
      default: begin
        n = $urandom_range(1, 5);
        for (int unsigned i = 1; i <= n; i++) add_push(i == n);
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned goal;
    // stack overflow, with the number extremes in the pushes
    for (int unsigned i = 0; i < STACK_N; i++)
      add_token(OP_NUM, (i % 3 == 0) ? Q_MAX : (i % 3 == 1) ? Q_MIN : Q_ZERO, 1'b0);
    add_token(OP_NUM, 32'hFFFF_FFFF, 1'b1);
    // saturating add, multiply and subtract, then a divide by zero
    add_token(OP_NUM, Q_MAX, 1'b0);
    add_token(OP_NUM, Q_MAX, 1'b0);
    add_token(OP_ADD, Q_ZERO, 1'b0);
    add_token(OP_NUM, Q_MIN, 1'b0);
    add_token(OP_MUL, Q_ZERO, 1'b0);
    add_token(OP_NUM, Q_LSB, 1'b0);
    add_token(OP_SUB, Q_ZERO, 1'b0);
    add_token(OP_NUM, Q_ZERO, 1'b0);
    add_token(OP_DIV, Q_ONE, 1'b1);
    // underflow on an empty stack, invalid token code
    add_token(OP_ADD, Q_ZERO, 1'b1);
    add_token(OP_CODE_MAX, 32'hFFFF_FFFF, 1'b1);

    goal = tokens_planned + RANDOM_TOKENS;
    while (tokens_planned < goal) begin
      if ($urandom_range(0, 4) == 0) add_broken();
      else add_well_formed();
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (tokens_in < tokens_planned || rpn_outcomes.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (rpn_outcomes.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, rpn_outcomes.size());
      errors++;
    end

    $display("%0d tokens in %0d expressions, %0d results checked", tokens_in, verdicts,
             results_seen);
    $display("verdicts: ok %0d, div by zero %0d, underflow %0d, overflow %0d, bad end %0d",
             verdict_hits[ST_OK], verdict_hits[ST_DIVZERO], verdict_hits[ST_UNDER],
             verdict_hits[ST_OVER], verdict_hits[ST_BADEND]);
    if (errors == 0) begin
      $display("postfix_expression_evaluator_core regression: pass");
    end else begin
      $display("postfix_expression_evaluator_core regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  always @(negedge clk_i) begin : drive_tokens
    token_t t;
    logic   v;
    if (rst_ni) begin
      v = 1'b0;
      if (tok_valid && !tok_acc) begin
        v = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (token_stream.size() > 0) begin
        t = token_stream.pop_front();
        tok_op   <= t.op;
        tok_num  <= t.num;
        tok_last <= t.last;
        v = 1'b1;
        tx_gap = idle_len();
      end
      tok_valid <= v;
    end
  end

  always @(negedge clk_i) begin : drive_ready
    logic r;
    if (rst_ni) begin
      r = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        r = 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = idle_len();
      end
      res_ready <= r;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch_streams
    token_t   t;
    outcome_t want;
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cyc);
      $display("postfix_expression_evaluator_core regression: fail");
      $finish;
    end else if (rst_ni) begin
      tok_acc <= tok_valid && tok_ready;
      if (tok_valid && tok_ready) begin
        t.op   = tok_op;
        t.num  = tok_num;
        t.last = tok_last;
        rpn_evaluate_token(t);
        tokens_in <= tokens_in + 1;
      end
      if (res_valid && res_ready) begin
        results_seen <= results_seen + 1;
        if (rpn_outcomes.size() == 0) begin
          $display("%0t: unexpected result: status %0d top %h last %b", $time,
                   res_status, res_top, res_done);
          errors++;
        end else begin
          want = rpn_outcomes.pop_front();
          if (res_status !== want.status || res_top !== want.top ||
              res_done !== want.done) begin
            $display("%0t: mismatch: expected status %0d top %h last %b, got %0d %h %b",
                     $time, want.status, want.top, want.done, res_status, res_top,
                     res_done);
            errors++;
          end
          if (want.done) begin
            verdicts <= verdicts + 1;
            verdict_hits[want.status]++;
          end
        end
      end
    end
  end

endmodule
